// File: hw/rtl/ljc_pkg.sv
// Shared types, register indexes, step codes and constants of the pair energy unit.
`default_nettype none

package ljc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 232;

    localparam logic [CFG_IDX_W-1:0] CFG_VDW_CUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEC_CUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WELL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VDW_WT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEC_WT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_EN   = 3'd6;

    localparam logic [31:0] RST_VDW_CUT  = 32'd4194304;
    localparam logic [31:0] RST_ELEC_CUT = 32'd6553600;
    localparam logic [23:0] RST_ONE_Q16  = 24'd65536;

    localparam int MAX_B_ATOMS = 4096;

    localparam logic [60:0] SAT_CAP    = 61'(1) << 60;
    localparam logic [60:0] SAT_CAP_12 = SAT_CAP / 12;
    localparam logic [24:0] COULOMB_K  = 25'd21762127;
    localparam logic [49:0] D2_ONE     = 50'd65536;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_16 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;

    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_SQ0    = 6'd1;
    localparam logic [5:0] ST_SQ1    = 6'd2;
    localparam logic [5:0] ST_SQ2    = 6'd3;
    localparam logic [5:0] ST_CUT    = 6'd4;
    localparam logic [5:0] ST_RAT0   = 6'd5;
    localparam logic [5:0] ST_RAT1   = 6'd6;
    localparam logic [5:0] ST_RAT2   = 6'd7;
    localparam logic [5:0] ST_RSQ    = 6'd8;
    localparam logic [5:0] ST_A2     = 6'd9;
    localparam logic [5:0] ST_A4     = 6'd10;
    localparam logic [5:0] ST_A6     = 6'd11;
    localparam logic [5:0] ST_T6     = 6'd12;
    localparam logic [5:0] ST_T12    = 6'd13;
    localparam logic [5:0] ST_EVDW   = 6'd14;
    localparam logic [5:0] ST_VM     = 6'd15;
    localparam logic [5:0] ST_VG0    = 6'd16;
    localparam logic [5:0] ST_VG1    = 6'd17;
    localparam logic [5:0] ST_VG2    = 6'd18;
    localparam logic [5:0] ST_DIST   = 6'd19;
    localparam logic [5:0] ST_QM     = 6'd20;
    localparam logic [5:0] ST_NUM    = 6'd21;
    localparam logic [5:0] ST_DEN    = 6'd22;
    localparam logic [5:0] ST_EM     = 6'd23;
    localparam logic [5:0] ST_EELEC  = 6'd24;
    localparam logic [5:0] ST_EGA0   = 6'd25;
    localparam logic [5:0] ST_EGB0   = 6'd26;
    localparam logic [5:0] ST_EGA1   = 6'd27;
    localparam logic [5:0] ST_EGB1   = 6'd28;
    localparam logic [5:0] ST_EGA2   = 6'd29;
    localparam logic [5:0] ST_EGB2   = 6'd30;
    localparam logic [5:0] ST_FINISH = 6'd31;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [5:0] step;
    } ctl_cmd_t;

    typedef struct packed {
        logic done;
        logic in_vdw;
        logic in_elec;
        logic q_nz;
        logic gon;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/ljc_mul.sv
// Iterative 64x64 multiplier, 16-bit digit per cycle, with shift and saturation.
`default_nettype none

module ljc_mul
    import ljc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire logic [1:0]  sh,
    output logic             done,
    output logic [60:0]      res
);

    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [1:0]   sh_reg, sh_next;
    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic         done_reg, done_next;
    logic [60:0]  res_reg, res_next;
    logic [79:0]  upper;
    logic [127:0] sv;
    logic         sat;

    always_comb
    begin
        upper = {16'b0, acc_reg[127:64]} + (a_reg * b_reg[15:0]);
        unique case (sh_reg)
            SH_16:   sv = acc_reg >> 16;
            SH_32:   sv = acc_reg >> 32;
            default: sv = acc_reg;
        endcase
        sat = (|sv[127:61]) | (sv[60] & (|sv[59:0]));

        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            sh_next   = sh;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {upper, acc_reg[63:16]};
            b_next   = b_reg >> 16;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            res_next  = sat ? SAT_CAP : sv[60:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ljc_div.sv
// Restoring divider, 64-bit dividend by 48-bit divisor, one quotient bit per cycle.
`default_nettype none

module ljc_div
    import ljc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [47:0] divisor,
    output logic             done,
    output logic [63:0]      quot
);

    logic [63:0] q_reg, q_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] rs;
    logic [48:0] diff;
    logic        ge;

    always_comb
    begin
        rs   = {rem_reg, q_reg[63]};
        diff = rs - {1'b0, dvs_reg};
        ge   = rs >= {1'b0, dvs_reg};

        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[47:0] : rs[47:0];
            q_next   = {q_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ljc_ctrl.sv
// Step sequencer of the pair energy unit.
`default_nettype none

module ljc_ctrl
    import ljc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctl_cmd_t        cmd
);

    logic [5:0] state_reg, state_next;
    logic       issued_reg, issued_next;
    logic [5:0] after;
    logic [5:0] elec_entry;

    always_comb
    begin
        elec_entry = (status.in_elec && status.q_nz) ? ST_DIST : ST_FINISH;
        unique case (state_reg)
            ST_SQ0:    after = ST_SQ1;
            ST_SQ1:    after = ST_SQ2;
            ST_SQ2:    after = ST_CUT;
            ST_CUT:    after = (status.in_vdw || status.in_elec) ? ST_RAT0 : ST_FINISH;
            ST_RAT0:   after = ST_RAT1;
            ST_RAT1:   after = ST_RAT2;
            ST_RAT2:   after = status.in_vdw ? ST_RSQ : elec_entry;
            ST_RSQ:    after = ST_A2;
            ST_A2:     after = ST_A4;
            ST_A4:     after = ST_A6;
            ST_A6:     after = ST_T6;
            ST_T6:     after = ST_T12;
            ST_T12:    after = ST_EVDW;
            ST_EVDW:   after = status.gon ? ST_VM : elec_entry;
            ST_VM:     after = ST_VG0;
            ST_VG0:    after = ST_VG1;
            ST_VG1:    after = ST_VG2;
            ST_VG2:    after = elec_entry;
            ST_DIST:   after = ST_QM;
            ST_QM:     after = ST_NUM;
            ST_NUM:    after = ST_DEN;
            ST_DEN:    after = ST_EM;
            ST_EM:     after = ST_EELEC;
            ST_EELEC:  after = status.gon ? ST_EGA0 : ST_FINISH;
            ST_EGA0:   after = ST_EGB0;
            ST_EGB0:   after = ST_EGA1;
            ST_EGA1:   after = ST_EGB1;
            ST_EGB1:   after = ST_EGA2;
            ST_EGA2:   after = ST_EGB2;
            ST_EGB2:   after = ST_FINISH;
            default:   after = ST_IDLE;
        endcase

        state_next  = state_reg;
        issued_next = issued_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.start   = 1'b0;
        cmd.step    = state_reg;
        if (state_reg == ST_IDLE)
        begin
            in_ready = 1'b1;
            if (in_valid)
            begin
                cmd.load   = 1'b1;
                state_next = ST_SQ0;
            end
        end
        else if (!issued_reg)
        begin
            if (state_reg != ST_FINISH || status.out_free)
            begin
                cmd.start   = 1'b1;
                issued_next = 1'b1;
            end
        end
        else if (status.done)
        begin
            issued_next = 1'b0;
            state_next  = after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ljc_dp.sv
// Datapath: pair registers, configuration, arithmetic units, sums and output word.
`default_nettype none

module ljc_dp
    import ljc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctl_cmd_t              cmd,
    output dp_status_t                 status,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic                  in_last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data,
    output logic                       out_last
);

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF)
            return 48'sh7FFF_FFFF_FFFF;
        else if (v < -64'sh0000_8000_0000_0000)
            return 48'sh8000_0000_0000;
        else
            return v[47:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        if (v > 64'sh0000_007F_FFFF_FFFF)
            return 40'sh7F_FFFF_FFFF;
        else if (v < -64'sh0000_0080_0000_0000)
            return 40'sh80_0000_0000;
        else
            return v[39:0];
    endfunction

    // configuration
    logic [31:0] vcut_reg, ecut_reg;
    logic [23:0] well_reg, diel_reg, wv_reg, we_reg;
    logic        gen_reg;

    // pair state
    logic [31:0]        mag_reg [3];
    logic [2:0]         dneg_reg;
    logic [16:0]        rmin_reg;
    logic [15:0]        qa_reg, qb_reg;
    logic               qneg_reg, qnz_reg, gon_reg, last_reg;
    logic [11:0]        idx_reg;
    logic [49:0]        d2_reg;
    logic [31:0]        d2c_reg;
    logic               invdw_reg, inelec_reg;
    logic [39:0]        ratio_reg [3];
    logic [60:0]        tmp_reg;
    logic [25:0]        a2_reg;
    logic [36:0]        a4_reg;
    logic [46:0]        a6_reg;
    logic [60:0]        t6_reg, t12_reg, pabs_reg, m_reg;
    logic               pneg_reg;
    logic [23:0]        dist_reg;
    logic [30:0]        qm_reg;
    logic [55:0]        num_reg;
    logic [47:0]        den_reg;
    logic [47:0]        em_reg;
    logic signed [62:0] gsum_reg [3];
    logic signed [47:0] vacc_reg, eacc_reg;

    // output word
    logic                   ovalid_reg;
    logic [OUT_DATA_W-1:0]  odata_reg;
    logic                   olast_reg;

    // square root
    logic [47:0] sv_reg, sr_reg, sbit_reg;
    logic [4:0]  scnt_reg;
    logic        sbusy_reg, sdone_reg;
    logic [48:0] strial;

    logic        single_done_reg;

    // units
    logic        mul_start, div_start, sqrt_start, single_start;
    logic [63:0] mul_a, mul_b, div_n;
    logic [47:0] div_d;
    logic [1:0]  mul_sh;
    logic        mul_done, div_done;
    logic [60:0] mul_res;
    logic [63:0] div_q;

    // pair decode
    logic signed [32:0] dsub [3];
    logic [31:0]        dmag [3];
    logic signed [15:0] qa_in, qb_in;
    logic [11:0]        idx_in;
    logic [23:0]        diel_eff;
    logic [1:0]         gsel;
    logic               gvdw, gelec;
    logic signed [63:0] gadd;
    logic signed [63:0] e64, p64, ev64;
    logic signed [47:0] evdw;
    logic signed [63:0] gext [3];

    ljc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .sh    (mul_sh),
        .done  (mul_done),
        .res   (mul_res)
    );

    ljc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_q)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsub[i] = {in_data[32*i+31], in_data[32*i +: 32]}
                    - {in_data[32*i+127], in_data[32*i+96 +: 32]};
            dmag[i] = dsub[i][32] ? 32'(-dsub[i]) : dsub[i][31:0];
            gext[i] = 64'(gsum_reg[i]);
        end
        qa_in    = in_data[239:224];
        qb_in    = in_data[255:240];
        idx_in   = in_data[267:256];
        diel_eff = (diel_reg == '0) ? 24'd1 : diel_reg;

        e64  = $signed({3'b0, t12_reg}) - $signed({2'b0, t6_reg, 1'b0});
        evdw = sat48(e64);
        p64  = $signed({3'b0, t6_reg}) - $signed({3'b0, t12_reg});
        ev64 = qneg_reg ? -$signed({16'b0, em_reg}) : $signed({16'b0, em_reg});
        strial = {1'b0, sr_reg} + {1'b0, sbit_reg};

        mul_start    = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        single_start = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = SH_0;
        div_n  = '0;
        div_d  = {16'b0, d2c_reg};
        gsel   = 2'd0;
        gvdw   = 1'b0;
        gelec  = 1'b0;
        unique case (cmd.step)
            ST_SQ0, ST_SQ1, ST_SQ2:
            begin
                gsel   = 2'(cmd.step - ST_SQ0);
                mul_a  = 64'(mag_reg[gsel]);
                mul_b  = 64'(mag_reg[gsel]);
                mul_sh = SH_16;
                mul_start = cmd.start;
            end
            ST_RAT0, ST_RAT1, ST_RAT2:
            begin
                gsel  = 2'(cmd.step - ST_RAT0);
                div_n = {mag_reg[gsel], 32'b0};
                div_start = cmd.start;
            end
            ST_RSQ:
            begin
                mul_a = 64'(rmin_reg);
                mul_b = 64'(rmin_reg);
                mul_start = cmd.start;
            end
            ST_A2:
            begin
                div_n = {tmp_reg[55:0], 8'b0};
                div_start = cmd.start;
            end
            ST_A4:
            begin
                mul_a = 64'(a2_reg);
                mul_b = 64'(a2_reg);
                mul_sh = SH_16;
                mul_start = cmd.start;
            end
            ST_A6:
            begin
                mul_a = 64'(a4_reg);
                mul_b = 64'(a2_reg);
                mul_sh = SH_16;
                mul_start = cmd.start;
            end
            ST_T6:
            begin
                mul_a = 64'(well_reg);
                mul_b = 64'(a6_reg);
                mul_sh = SH_16;
                mul_start = cmd.start;
            end
            ST_T12:
            begin
                mul_a = 64'(t6_reg);
                mul_b = 64'(a6_reg);
                mul_sh = SH_16;
                mul_start = cmd.start;
            end
            ST_VM:
            begin
                mul_a = 64'(pabs_reg);
                mul_b = 64'(wv_reg);
                mul_sh = SH_16;
                mul_start = cmd.start;
            end
            ST_VG0, ST_VG1, ST_VG2:
            begin
                gsel  = 2'(cmd.step - ST_VG0);
                gvdw  = 1'b1;
                mul_a = 64'(m_reg);
                mul_b = 64'(ratio_reg[gsel]);
                mul_sh = SH_32;
                mul_start = cmd.start;
            end
            ST_DIST:
                sqrt_start = cmd.start;
            ST_QM:
            begin
                mul_a = 64'(qa_reg);
                mul_b = 64'(qb_reg);
                mul_start = cmd.start;
            end
            ST_NUM:
            begin
                mul_a = 64'(COULOMB_K);
                mul_b = 64'(qm_reg);
                mul_start = cmd.start;
            end
            ST_DEN:
            begin
                mul_a = 64'(diel_eff);
                mul_b = 64'(dist_reg);
                mul_start = cmd.start;
            end
            ST_EM:
            begin
                div_n = {num_reg, 8'b0};
                div_d = den_reg;
                div_start = cmd.start;
            end
            ST_EGA0, ST_EGA1, ST_EGA2:
            begin
                gsel  = 2'((cmd.step - ST_EGA0) >> 1);
                mul_a = 64'(em_reg);
                mul_b = 64'(ratio_reg[gsel]);
                mul_sh = SH_32;
                mul_start = cmd.start;
            end
            ST_EGB0, ST_EGB1, ST_EGB2:
            begin
                gsel  = 2'((cmd.step - ST_EGB0) >> 1);
                gelec = 1'b1;
                mul_a = 64'(tmp_reg);
                mul_b = 64'(we_reg);
                mul_sh = SH_16;
                mul_start = cmd.start;
            end
            ST_CUT, ST_EVDW, ST_EELEC, ST_FINISH:
                single_start = cmd.start;
            default:
            begin
            end
        endcase

        if (gvdw)
            gadd = (pneg_reg == dneg_reg[gsel]) ? -$signed({3'b0, mul_res})
                                                 : $signed({3'b0, mul_res});
        else
            gadd = (qneg_reg != dneg_reg[gsel]) ? -$signed({3'b0, mul_res})
                                                 : $signed({3'b0, mul_res});
    end

    // configuration, control flags and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcut_reg        <= RST_VDW_CUT;
            ecut_reg        <= RST_ELEC_CUT;
            well_reg        <= RST_ONE_Q16;
            diel_reg        <= RST_ONE_Q16;
            wv_reg          <= RST_ONE_Q16;
            we_reg          <= RST_ONE_Q16;
            gen_reg         <= 1'b0;
            vacc_reg        <= '0;
            eacc_reg        <= '0;
            ovalid_reg      <= 1'b0;
            sbusy_reg       <= 1'b0;
            sdone_reg       <= 1'b0;
            scnt_reg        <= '0;
            single_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_VDW_CUT:  vcut_reg <= cfg_data;
                    CFG_ELEC_CUT: ecut_reg <= cfg_data;
                    CFG_WELL:     well_reg <= cfg_data[23:0];
                    CFG_DIEL:     diel_reg <= cfg_data[23:0];
                    CFG_VDW_WT:   wv_reg   <= cfg_data[23:0];
                    CFG_ELEC_WT:  we_reg   <= cfg_data[23:0];
                    CFG_GRAD_EN:  gen_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            single_done_reg <= single_start;

            if (single_start && cmd.step == ST_EVDW)
                vacc_reg <= sat48(64'(vacc_reg) + 64'(evdw));
            if (single_start && cmd.step == ST_EELEC)
                eacc_reg <= sat48(64'(eacc_reg) + ev64);

            if (single_start && cmd.step == ST_FINISH)
            begin
                ovalid_reg <= 1'b1;
                if (last_reg)
                begin
                    vacc_reg <= '0;
                    eacc_reg <= '0;
                end
            end
            else if (out_ready)
                ovalid_reg <= 1'b0;

            sdone_reg <= 1'b0;
            if (sqrt_start)
            begin
                sbusy_reg <= 1'b1;
                scnt_reg  <= '0;
            end
            else if (sbusy_reg)
            begin
                scnt_reg <= scnt_reg + 5'd1;
                if (scnt_reg == 5'd23)
                begin
                    sbusy_reg <= 1'b0;
                    sdone_reg <= 1'b1;
                end
            end
        end
    end

    // pair payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= dmag[i];
                dneg_reg[i] <= dsub[i][32];
                gsum_reg[i] <= '0;
            end
            rmin_reg <= {1'b0, in_data[207:192]} + {1'b0, in_data[223:208]};
            qa_reg   <= qa_in[15] ? 16'(-qa_in) : qa_in;
            qb_reg   <= qb_in[15] ? 16'(-qb_in) : qb_in;
            qneg_reg <= qa_in[15] ^ qb_in[15];
            qnz_reg  <= (qa_in != '0) && (qb_in != '0);
            idx_reg  <= idx_in;
            last_reg <= in_last;
            gon_reg  <= gen_reg && ({20'b0, idx_in} < 32'(MAX_B_ATOMS));
            d2_reg   <= '0;
        end

        if (single_start && cmd.step == ST_CUT)
        begin
            d2c_reg    <= (d2_reg < D2_ONE) ? D2_ONE[31:0] : d2_reg[31:0];
            invdw_reg  <= d2_reg < {18'b0, vcut_reg};
            inelec_reg <= d2_reg < {18'b0, ecut_reg};
        end

        if (single_start && cmd.step == ST_EVDW)
        begin
            pneg_reg <= p64[63];
            pabs_reg <= p64[63] ? 61'(-p64) : p64[60:0];
        end

        if (single_start && cmd.step == ST_FINISH)
        begin
            odata_reg <= {4'b0, eacc_reg, vacc_reg, sat40(gext[2]), sat40(gext[1]),
                          sat40(gext[0]), idx_reg};
            olast_reg <= last_reg;
        end

        if (mul_done)
        begin
            unique case (cmd.step)
                ST_SQ0, ST_SQ1, ST_SQ2: d2_reg <= d2_reg + mul_res[49:0];
                ST_RSQ:  tmp_reg <= mul_res;
                ST_A4:   a4_reg  <= mul_res[36:0];
                ST_A6:   a6_reg  <= mul_res[46:0];
                ST_T6:   t6_reg  <= mul_res;
                ST_T12:  t12_reg <= mul_res;
                ST_VM:   m_reg   <= (mul_res >= SAT_CAP_12) ? SAT_CAP
                                  : (mul_res << 3) + (mul_res << 2);
                ST_QM:   qm_reg  <= mul_res[30:0];
                ST_NUM:  num_reg <= mul_res[55:0];
                ST_DEN:  den_reg <= mul_res[47:0];
                ST_EGA0, ST_EGA1, ST_EGA2: tmp_reg <= mul_res;
                ST_VG0, ST_VG1, ST_VG2, ST_EGB0, ST_EGB1, ST_EGB2:
                    gsum_reg[gsel] <= 63'(gext[gsel] + gadd);
                default:
                begin
                end
            endcase
        end

        if (div_done)
        begin
            unique case (cmd.step)
                ST_RAT0, ST_RAT1, ST_RAT2: ratio_reg[gsel] <= div_q[39:0];
                ST_A2:   a2_reg <= div_q[25:0];
                ST_EM:   em_reg <= div_q[47:0];
                default:
                begin
                end
            endcase
        end

        if (sqrt_start)
        begin
            sv_reg   <= {d2c_reg, 16'b0};
            sr_reg   <= '0;
            sbit_reg <= 48'(1) << 46;
        end
        else if (sbusy_reg)
        begin
            if ({1'b0, sv_reg} >= strial)
            begin
                sv_reg <= sv_reg - strial[47:0];
                sr_reg <= (sr_reg >> 1) + sbit_reg;
            end
            else
                sr_reg <= sr_reg >> 1;
            sbit_reg <= sbit_reg >> 2;
        end

        if (sdone_reg)
            dist_reg <= sr_reg[23:0];
    end

    always_comb
    begin
        status.done     = mul_done | div_done | sdone_reg | single_done_reg;
        status.in_vdw   = invdw_reg;
        status.in_elec  = inelec_reg;
        status.q_nz     = qnz_reg;
        status.gon      = gon_reg;
        status.out_free = !ovalid_reg || out_ready;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lj_coulomb_pair_energy_accumulator_unit.sv
// Top level: Lennard-Jones and Coulomb pair energy accumulator with weighted gradients.
// A pair's steps run on the bit-serial divider (five divisions with both terms), the
// 24-step square root and the four-digit multiplier. One pair is in work at a time; the
// next word is taken only after the result loads into the output register.
// Reset (rst_n low, asynchronous) clears sums, loads register defaults, empties output.
`default_nettype none

module lj_coulomb_pair_energy_accumulator_unit
    import ljc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, a_radius, b_radius, a_charge, b_charge,
    // b_atom_index, zero fill
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // grad_atom_index, grad_x, grad_y, grad_z, vdw_energy_sum, elec_energy_sum,
    // zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    ljc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ljc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
